>>> rtl/mlcd_pkg.sv
package mlcd_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_NEXT     = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_MARK_ALL = 2'd3
  } action_e;

  localparam logic [1:0] KIND_LINES = 2'd0;
  localparam logic [1:0] KIND_VCOM  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] CMD_LINES = 8'h80;
  localparam logic [7:0] CMD_CLEAR = 8'h20;
  localparam logic [7:0] CMD_VCOM  = 8'h00;
  localparam logic [7:0] VCOM_BIT  = 8'h40;
  localparam logic [7:0] TRAILER   = 8'h00;

  // request from the transfer control to the frame store
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [2:0] bit_sel;
    logic       value;
  } frame_ctl_t;

  typedef struct packed {
    logic init_done;
    logic busy;
    logic rd_valid;
  } frame_sts_t;

  function automatic logic [7:0] reverse_bits(input logic [7:0] b);
    logic [7:0] v;
    v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
    return v;
  endfunction

endpackage

>>> rtl/mlcd_if.sv
interface mlcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_value;

  modport source (output valid, output action, output pixel_x, output pixel_y,
                  output pixel_value, input ready);
  modport sink (input valid, input action, input pixel_x, input pixel_y,
                input pixel_value, output ready);
endinterface

interface mlcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       transfer_end;
  logic [1:0] transfer_kind;

  modport source (output valid, output spi_byte, output transfer_end,
                  output transfer_kind, input ready);
  modport sink (input valid, input spi_byte, input transfer_end,
                input transfer_kind, output ready);
endinterface

>>> rtl/mlcd_frame_store.sv
module mlcd_frame_store #(
  parameter int unsigned DEPTH = 12000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlcd_pkg::frame_ctl_t ctl_i,
  input  logic [AW-1:0]       addr_i,
  output logic [7:0]          rd_data_o,
  output mlcd_pkg::frame_sts_t sts_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;
  logic          rd_pend_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic [2:0]    bit_q;
  logic          val_q;
  logic [7:0]    mask;
  logic [7:0]    merged;

  assign mask   = 8'h80 >> bit_q;
  assign merged = val_q ? (rd_q | mask) : (rd_q & ~mask);

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (wr_pend_q) begin
      mem[wr_addr_q] <= merged;
    end
    if (ctl_i.rd || ctl_i.wr) begin
      rd_q <= mem[addr_i];
    end
  end

  // pixel write: read this cycle, merge and write back the next
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      wr_addr_q <= addr_i;
      bit_q     <= ctl_i.bit_sel;
      val_q     <= ctl_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      rd_pend_q  <= 1'b0;
      wr_pend_q  <= 1'b0;
    end else begin
      if (clearing_q) begin
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      rd_pend_q <= ctl_i.rd;
      wr_pend_q <= ctl_i.wr;
    end
  end

  assign rd_data_o       = rd_q;
  assign sts_o.init_done = !clearing_q;
  assign sts_o.busy      = wr_pend_q;
  assign sts_o.rd_valid  = rd_pend_q;

endmodule

>>> rtl/memory_lcd_dirty_line_refresh_core.sv
// channel | dir | words
// in_i    | in  | action, pixel_x, pixel_y, pixel_value
// out_o   | out | spi_byte, transfer_end, transfer_kind
//
// One item at a time: a pixel write reads the frame store, then merges and writes back,
// a pixel byte waits for one frame store read, and an address byte or trailer waits
// for the dirty-line scan, which checks one line per cycle.
// After reset the frame store is cleared one byte a cycle, LINE_COUNT * line bytes
// in all (12000 by default), with in_i.ready low.
// A full output register lets the next item in; only a result stalls on it.
module memory_lcd_dirty_line_refresh_core #(
  parameter int unsigned LINE_PIXELS = 400,
  parameter int unsigned LINE_COUNT  = 240
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlcd_in_if.sink    in_i,
  mlcd_out_if.source out_o
);

  localparam int unsigned LINE_BYTES  = (LINE_PIXELS + 7) / 8;
  localparam int unsigned STORE_BYTES = LINE_COUNT * LINE_BYTES;
  localparam int unsigned AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned LW  = $clog2(LINE_COUNT + 1);
  localparam int unsigned LIW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int unsigned BW  = $clog2(LINE_BYTES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_VCOM_TAIL = 3'd1;
  localparam logic [2:0] PH_SEARCH    = 3'd2;
  localparam logic [2:0] PH_DATA      = 3'd3;
  localparam logic [2:0] PH_LINE_TAIL = 3'd4;

  logic [2:0]            st_q, st_d;
  logic [2:0]            phase_q, phase_d;
  mlcd_pkg::action_e     act_q;
  logic [8:0]            px_q;
  logic [7:0]            py_q;
  logic                  pv_q;
  logic                  vcom_q, vcom_d;
  logic [LW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         base_q, base_d;
  logic [BW-1:0]         bil_q, bil_d;
  logic [LINE_COUNT-1:0] dirty_q, dirty_d;
  logic [LW-1:0]         dcnt_q, dcnt_d;
  logic [7:0]            res_byte_q, res_byte_d;
  logic                  res_end_q, res_end_d;
  logic [1:0]            res_kind_q, res_kind_d;
  logic                  clr2_q, clr2_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q;
  logic                  out_end_q;
  logic [1:0]            out_kind_q;
  logic                  out_load;

  mlcd_pkg::frame_ctl_t  fctl;
  mlcd_pkg::frame_sts_t  fsts;
  logic [AW-1:0]         faddr;
  logic [7:0]            frd;

  logic                  in_fire;
  logic                  out_free;
  logic                  in_range;
  logic [7:0]            vbit;
  logic [AW-1:0]         pix_addr;

  mlcd_frame_store #(.DEPTH(STORE_BYTES)) u_frame (
    .clk_i,
    .rst_ni,
    .ctl_i     (fctl),
    .addr_i    (faddr),
    .rd_data_o (frd),
    .sts_o     (fsts)
  );

  assign in_i.ready = (st_q == S_IDLE) && fsts.init_done && !fsts.busy;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid         = out_valid_q;
  assign out_o.spi_byte      = out_byte_q;
  assign out_o.transfer_end  = out_end_q;
  assign out_o.transfer_kind = out_kind_q;

  assign in_range = (32'(px_q) < LINE_PIXELS) && (32'(py_q) < LINE_COUNT);
  assign vbit     = vcom_q ? mlcd_pkg::VCOM_BIT : 8'h00;
  assign pix_addr = AW'(32'(py_q) * LINE_BYTES + 32'(px_q[8:3]));

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    vcom_d      = vcom_q;
    cur_d       = cur_q;
    base_d      = base_q;
    bil_d       = bil_q;
    dirty_d     = dirty_q;
    dcnt_d      = dcnt_q;
    res_byte_d  = res_byte_q;
    res_end_d   = res_end_q;
    res_kind_d  = res_kind_q;
    clr2_d      = clr2_q;
    out_load    = 1'b0;
    fctl        = '0;
    faddr       = '0;

    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        st_d = S_IDLE;
        case (act_q)
          mlcd_pkg::ACT_WRITE: begin
            if (in_range) begin
              fctl.wr      = 1'b1;
              fctl.bit_sel = px_q[2:0];
              fctl.value   = pv_q;
              faddr        = pix_addr;
              dirty_d[py_q[LIW-1:0]] = 1'b1;
              if (!dirty_q[py_q[LIW-1:0]]) begin
                dcnt_d = dcnt_q + LW'(1);
              end
            end
          end
          mlcd_pkg::ACT_MARK_ALL: begin
            dirty_d = '1;
            dcnt_d  = LW'(LINE_COUNT);
          end
          mlcd_pkg::ACT_CLEAR: begin
            if (phase_q == PH_IDLE) begin
              res_byte_d = mlcd_pkg::CMD_CLEAR | vbit;
              res_end_d  = 1'b0;
              res_kind_d = mlcd_pkg::KIND_CLEAR;
              clr2_d     = 1'b1;
              vcom_d     = !vcom_q;
              st_d       = S_OUT;
            end
          end
          mlcd_pkg::ACT_NEXT: begin
            st_d = S_OUT;
            case (phase_q)
              PH_IDLE: begin
                res_end_d = 1'b0;
                if (dcnt_q != '0) begin
                  res_byte_d = mlcd_pkg::CMD_LINES | vbit;
                  res_kind_d = mlcd_pkg::KIND_LINES;
                  cur_d      = '0;
                  base_d     = '0;
                  phase_d    = PH_SEARCH;
                end else begin
                  res_byte_d = mlcd_pkg::CMD_VCOM | vbit;
                  res_kind_d = mlcd_pkg::KIND_VCOM;
                  phase_d    = PH_VCOM_TAIL;
                end
              end
              PH_VCOM_TAIL: begin
                res_byte_d = mlcd_pkg::TRAILER;
                res_end_d  = 1'b1;
                res_kind_d = mlcd_pkg::KIND_VCOM;
                vcom_d     = !vcom_q;
                phase_d    = PH_IDLE;
              end
              PH_SEARCH: begin
                st_d = S_SCAN;
              end
              PH_DATA: begin
                fctl.rd = 1'b1;
                faddr   = base_q + AW'(bil_q);
                st_d    = S_READ;
              end
              default: begin
                res_byte_d = mlcd_pkg::TRAILER;
                res_end_d  = 1'b0;
                res_kind_d = mlcd_pkg::KIND_LINES;
                cur_d      = cur_q + LW'(1);
                base_d     = base_q + AW'(LINE_BYTES);
                bil_d      = '0;
                phase_d    = PH_SEARCH;
              end
            endcase
          end
          default: begin
            st_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // check one line per cycle from the current line on
        res_kind_d = mlcd_pkg::KIND_LINES;
        if (cur_q == LW'(LINE_COUNT)) begin
          res_byte_d = mlcd_pkg::TRAILER;
          res_end_d  = 1'b1;
          vcom_d     = !vcom_q;
          cur_d      = '0;
          base_d     = '0;
          phase_d    = PH_IDLE;
          st_d       = S_OUT;
        end else if (dirty_q[cur_q[LIW-1:0]]) begin
          dirty_d[cur_q[LIW-1:0]] = 1'b0;
          dcnt_d     = dcnt_q - LW'(1);
          bil_d      = '0;
          res_byte_d = mlcd_pkg::reverse_bits(8'(cur_q) + 8'd1);
          res_end_d  = 1'b0;
          phase_d    = PH_DATA;
          st_d       = S_OUT;
        end else begin
          cur_d  = cur_q + LW'(1);
          base_d = base_q + AW'(LINE_BYTES);
        end
      end
      S_READ: begin
        if (fsts.rd_valid) begin
          res_byte_d = frd;
          res_end_d  = 1'b0;
          res_kind_d = mlcd_pkg::KIND_LINES;
          bil_d      = bil_q + BW'(1);
          if (bil_q == BW'(LINE_BYTES - 1)) begin
            phase_d = PH_LINE_TAIL;
          end
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (clr2_q) begin
            // second word of the clear command
            res_byte_d = mlcd_pkg::TRAILER;
            res_end_d  = 1'b1;
            res_kind_d = mlcd_pkg::KIND_CLEAR;
            clr2_d     = 1'b0;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= mlcd_pkg::action_e'(in_i.action);
      px_q  <= in_i.pixel_x;
      py_q  <= in_i.pixel_y;
      pv_q  <= in_i.pixel_value;
    end
    res_byte_q <= res_byte_d;
    res_end_q  <= res_end_d;
    res_kind_q <= res_kind_d;
    if (out_load) begin
      out_byte_q <= res_byte_q;
      out_end_q  <= res_end_q;
      out_kind_q <= res_kind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= PH_IDLE;
      vcom_q      <= 1'b1;
      cur_q       <= '0;
      base_q      <= '0;
      bil_q       <= '0;
      dirty_q     <= '0;
      dcnt_q      <= '0;
      clr2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      vcom_q      <= vcom_d;
      cur_q       <= cur_d;
      base_q      <= base_d;
      bil_q       <= bil_d;
      dirty_q     <= dirty_d;
      dcnt_q      <= dcnt_d;
      clr2_q      <= clr2_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LINE_PIXELS  = 400;
  localparam int unsigned LINE_COUNT   = 240;
  localparam int unsigned LINE_BYTES   = (LINE_PIXELS + 7) / 8;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_VCOM_TAIL,
    SEQ_SEARCH,
    SEQ_DATA,
    SEQ_LINE_TAIL
  } refresh_phase_e;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       transfer_end;
    logic [1:0] transfer_kind;
  } spi_word_t;

  typedef struct packed {
    mlcd_pkg::action_e act;
    logic [8:0]        x;
    logic [7:0]        y;
    logic              v;
    logic [2:0]        gap;
    logic              drain;
  } lcd_op_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  mlcd_in_if  in_bus ();
  mlcd_out_if out_bus ();

  logic       drv_valid  = 1'b0;
  logic [1:0] drv_action = mlcd_pkg::ACT_WRITE;
  logic [8:0] drv_x      = '0;
  logic [7:0] drv_y      = '0;
  logic       drv_value  = 1'b0;
  logic       mon_ready  = 1'b0;

  assign in_bus.valid       = drv_valid;
  assign in_bus.action      = drv_action;
  assign in_bus.pixel_x     = drv_x;
  assign in_bus.pixel_y     = drv_y;
  assign in_bus.pixel_value = drv_value;
  assign out_bus.ready      = mon_ready;

  memory_lcd_dirty_line_refresh_core #(
    .LINE_PIXELS(LINE_PIXELS),
    .LINE_COUNT (LINE_COUNT)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // display model: frame, dirty marks, VCOM and transfer position
  bit [7:0]            frame_mem [LINE_COUNT * LINE_BYTES];
  bit [LINE_COUNT-1:0] line_dirty = '0;
  bit                  vcom_level = 1'b1;
  refresh_phase_e      phase_q    = SEQ_IDLE;
  int unsigned         cur_line   = 0;
  int unsigned         byte_idx   = 0;

  spi_word_t expected_words [$];
  lcd_op_t   pending_ops [$];
  int        fail_count  = 0;

  function automatic void queue_word(logic [7:0] b, logic e, logic [1:0] k);
    expected_words.push_back({b, e, k});
  endfunction

  function automatic void predict_op(mlcd_pkg::action_e a, logic [8:0] x, logic [7:0] y,
                                     logic v);
    int unsigned idx;
    int unsigned ln;
    logic [7:0]  mask;
    logic [7:0]  num;
    logic [7:0]  rev;
    logic [7:0]  vb;
    int          i;
    vb = vcom_level ? mlcd_pkg::VCOM_BIT : '0;
    case (a)
      mlcd_pkg::ACT_WRITE: begin
        if (x < LINE_PIXELS && y < LINE_COUNT) begin
          idx  = y * LINE_BYTES + x / 8;
          mask = 8'h80 >> x[2:0];
          frame_mem[idx] = v ? (frame_mem[idx] | mask) : (frame_mem[idx] & ~mask);
          line_dirty[y] = 1'b1;
        end
      end
      mlcd_pkg::ACT_MARK_ALL: line_dirty = '1;
      mlcd_pkg::ACT_CLEAR: begin
        // ignored while a refresh is under way
        if (phase_q == SEQ_IDLE) begin
          queue_word(mlcd_pkg::CMD_CLEAR | vb, 1'b0, mlcd_pkg::KIND_CLEAR);
          queue_word(mlcd_pkg::TRAILER, 1'b1, mlcd_pkg::KIND_CLEAR);
          vcom_level = ~vcom_level;
        end
      end
      default: begin
        case (phase_q)
          SEQ_IDLE: begin
            if (line_dirty != '0) begin
              queue_word(mlcd_pkg::CMD_LINES | vb, 1'b0, mlcd_pkg::KIND_LINES);
              cur_line = 0;
              phase_q  = SEQ_SEARCH;
            end else begin
              queue_word(mlcd_pkg::CMD_VCOM | vb, 1'b0, mlcd_pkg::KIND_VCOM);
              phase_q = SEQ_VCOM_TAIL;
            end
          end
          SEQ_VCOM_TAIL: begin
            queue_word(mlcd_pkg::TRAILER, 1'b1, mlcd_pkg::KIND_VCOM);
            vcom_level = ~vcom_level;
            phase_q    = SEQ_IDLE;
          end
          SEQ_SEARCH: begin
            ln = cur_line;
            while (ln < LINE_COUNT && !line_dirty[ln]) ln++;
            if (ln < LINE_COUNT) begin
              line_dirty[ln] = 1'b0;
              cur_line = ln;
              byte_idx = 0;
              num = 8'(ln + 1);
              for (i = 0; i < 8; i++) rev[i] = num[7-i];
              queue_word(rev, 1'b0, mlcd_pkg::KIND_LINES);
              phase_q = SEQ_DATA;
            end else begin
              queue_word(mlcd_pkg::TRAILER, 1'b1, mlcd_pkg::KIND_LINES);
              vcom_level = ~vcom_level;
              cur_line   = 0;
              phase_q    = SEQ_IDLE;
            end
          end
          SEQ_DATA: begin
            queue_word(frame_mem[cur_line * LINE_BYTES + byte_idx], 1'b0,
                       mlcd_pkg::KIND_LINES);
            byte_idx++;
            if (byte_idx >= LINE_BYTES) phase_q = SEQ_LINE_TAIL;
          end
          default: begin
            queue_word(mlcd_pkg::TRAILER, 1'b0, mlcd_pkg::KIND_LINES);
            cur_line++;
            byte_idx = 0;
            phase_q  = SEQ_SEARCH;
          end
        endcase
      end
    endcase
  endfunction

  // stimulus planning: lines that will be dirty when the next refresh starts
  bit [LINE_COUNT-1:0] plan_dirty   = '0;
  bit                  burst_mode   = 1'b0;
  bit                  drain_next   = 1'b0;
  int unsigned         random_items = 0;

  task automatic push_op(input mlcd_pkg::action_e a, input logic [8:0] x,
                         input logic [7:0] y, input logic v, input bit counted);
    lcd_op_t op;
    op.act   = a;
    op.x     = x;
    op.y     = y;
    op.v     = v;
    op.gap   = burst_mode ? 3'd0 : 3'($urandom_range(0, 6));
    op.drain = drain_next;
    drain_next = 1'b0;
    pending_ops.push_back(op);
    if (counted) random_items++;
  endtask

  task automatic push_plain(input mlcd_pkg::action_e a, input bit counted);
    push_op(a, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)), counted);
  endtask

  task automatic write_pixel(input int ln);
    push_op(mlcd_pkg::ACT_WRITE, 9'($urandom_range(0, LINE_PIXELS - 1)), 8'(ln),
            1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic noise_write();
    if ($urandom_range(0, 1))
      push_op(mlcd_pkg::ACT_WRITE, 9'($urandom_range(LINE_PIXELS, 511)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    else
      push_op(mlcd_pkg::ACT_WRITE, 9'($urandom_range(0, 511)),
              8'($urandom_range(LINE_COUNT, 255)), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // occasional word slipped into a running refresh; cur is the line last addressed
  task automatic side_op(input int cur, ref int lines[$]);
    int r;
    int y;
    int i;
    bit seen;
    r = $urandom_range(0, 99);
    if (r < 1) begin
      y = $urandom_range(0, LINE_COUNT - 1);
      write_pixel(y);
      if (y > cur) begin
        // join the refresh unless already queued
        seen = 1'b0;
        for (i = 0; i < lines.size(); i++) if (lines[i] == y) seen = 1'b1;
        if (!seen) begin
          i = 0;
          while (i < lines.size() && lines[i] < y) i++;
          lines.insert(i, y);
        end
      end else begin
        plan_dirty[y] = 1'b1;
      end
    end else if (r < 2 && cur >= 0 && cur < LINE_COUNT) begin
      write_pixel(cur);
      plan_dirty[cur] = 1'b1;
    end else if (r < 3 && lines.size() != 0) begin
      write_pixel(lines[$urandom_range(0, lines.size() - 1)]);
    end else if (r < 4) begin
      noise_write();
    end else if (r < 5) begin
      push_plain(mlcd_pkg::ACT_CLEAR, 1'b0);
    end
  endtask

  // pull one complete refresh out of the block
  task automatic pull_transfer();
    int lines[$];
    int cur;
    int i;
    for (i = 0; i < LINE_COUNT; i++) if (plan_dirty[i]) lines.push_back(i);
    plan_dirty = '0;
    push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
    cur = (lines.size() == 0) ? LINE_COUNT : -1;
    side_op(cur, lines);
    if (cur == LINE_COUNT) begin
      push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
    end else begin
      while (lines.size() != 0) begin
        cur = lines.pop_front();
        push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
        for (i = 0; i < LINE_BYTES; i++) begin
          side_op(cur, lines);
          push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
        end
        side_op(cur, lines);
        push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
        side_op(cur, lines);
      end
      push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
    end
  endtask

  // driver
  logic [2:0] gap_left = '0;
  lcd_op_t    op_now;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_action <= mlcd_pkg::ACT_WRITE;
      drv_x      <= '0;
      drv_y      <= '0;
      drv_value  <= 1'b0;
      gap_left   <= '0;
    end else begin
      if (drv_valid && in_bus.ready)
        predict_op(mlcd_pkg::action_e'(drv_action), drv_x, drv_y, drv_value);
      if (!drv_valid || in_bus.ready) begin
        if (gap_left != 0) begin
          drv_valid <= 1'b0;
          gap_left  <= gap_left - 1'b1;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && expected_words.size() != 0)) begin
          op_now = pending_ops.pop_front();
          drv_valid  <= 1'b1;
          drv_action <= op_now.act;
          drv_x      <= op_now.x;
          drv_y      <= op_now.y;
          drv_value  <= op_now.v;
          gap_left   <= op_now.gap;
        end else begin
          // hold off: queue empty or waiting for the block to drain
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  int unsigned words_seen = 0;
  spi_word_t   exp_w;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_draw = stall_left;
      if (out_bus.valid && mon_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: spi_byte %02h transfer_end %0d transfer_kind %0d",
                 out_bus.spi_byte, out_bus.transfer_end, out_bus.transfer_kind);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_bus.spi_byte !== exp_w.spi_byte) begin
            $error("spi_byte: expected %02h, got %02h", exp_w.spi_byte, out_bus.spi_byte);
            fail_count++;
          end
          if (out_bus.transfer_end !== exp_w.transfer_end) begin
            $error("transfer_end: expected %0d, got %0d",
                   exp_w.transfer_end, out_bus.transfer_end);
            fail_count++;
          end
          if (out_bus.transfer_kind !== exp_w.transfer_kind) begin
            $error("transfer_kind: expected %0d, got %0d",
                   exp_w.transfer_kind, out_bus.transfer_kind);
            fail_count++;
          end
        end
        words_seen++;
        stall_draw = ((words_seen / 128) % 4 == 1) ? 0 : $urandom_range(0, 6);
      end
      if (stall_draw != 0) begin
        mon_ready  <= 1'b0;
        stall_left <= stall_draw - 1;
      end else begin
        mon_ready  <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("memory_lcd_dirty_line_refresh_core test failed");
      $finish;
    end
  end

  initial begin
    int unsigned seg_idx;
    int          r;
    int          n;
    int          ln;

    // directed: VCOM-only refresh, clear, clear inside a refresh
    push_plain(mlcd_pkg::ACT_NEXT, 1'b0);
    push_plain(mlcd_pkg::ACT_NEXT, 1'b0);
    push_plain(mlcd_pkg::ACT_CLEAR, 1'b0);
    push_plain(mlcd_pkg::ACT_NEXT, 1'b0);
    push_plain(mlcd_pkg::ACT_CLEAR, 1'b0);
    push_plain(mlcd_pkg::ACT_NEXT, 1'b0);
    // frame corners and byte boundaries
    push_op(mlcd_pkg::ACT_WRITE, 9'd0, 8'd0, 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'(LINE_PIXELS - 1), 8'(LINE_COUNT - 1), 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'd8, 8'd0, 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'd7, 8'(LINE_COUNT - 1), 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'd1, 8'd0, 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'd1, 8'd0, 1'b0, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'(LINE_PIXELS - 1), 8'd0, 1'b1, 1'b0);
    // outside the frame: drop
    push_op(mlcd_pkg::ACT_WRITE, 9'(LINE_PIXELS), 8'd0, 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'd511, 8'd255, 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'd0, 8'(LINE_COUNT), 1'b1, 1'b0);
    push_op(mlcd_pkg::ACT_WRITE, 9'(LINE_PIXELS - 1), 8'd255, 1'b0, 1'b0);
    // clear leaves the dirty marks alone
    push_plain(mlcd_pkg::ACT_CLEAR, 1'b0);
    plan_dirty[0] = 1'b1;
    plan_dirty[LINE_COUNT-1] = 1'b1;

    random_items = 0;
    seg_idx = 0;
    while (random_items < RANDOM_ITEMS) begin
      burst_mode = (seg_idx % 5 == 3);
      drain_next = (seg_idx % 7 == 6);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        n = $urandom_range(1, 2);
        repeat (n) begin
          r = $urandom_range(0, 9);
          ln = (r == 0) ? 0 : (r == 1) ? LINE_COUNT - 1 : $urandom_range(0, LINE_COUNT - 1);
          repeat ($urandom_range(1, 6)) write_pixel(ln);
          plan_dirty[ln] = 1'b1;
          if ($urandom_range(0, 3) == 0) noise_write();
        end
        pull_transfer();
      end else if (r < 8) begin
        push_plain(mlcd_pkg::ACT_CLEAR, 1'b1);
      end else if (plan_dirty == '0) begin
        pull_transfer();
      end else begin
        repeat ($urandom_range(1, 3)) noise_write();
        push_plain(mlcd_pkg::ACT_CLEAR, 1'b1);
      end
      seg_idx++;
    end

    // mark every line, then part of the resulting refresh
    burst_mode = 1'b0;
    push_plain(mlcd_pkg::ACT_MARK_ALL, 1'b1);
    repeat (40) begin
      push_plain(mlcd_pkg::ACT_NEXT, 1'b1);
      r = $urandom_range(0, 9);
      if (r == 0) write_pixel($urandom_range(0, LINE_COUNT - 1));
      else if (r == 1) push_plain(mlcd_pkg::ACT_CLEAR, 1'b0);
    end
    push_plain(mlcd_pkg::ACT_MARK_ALL, 1'b1);
    repeat (60) push_plain(mlcd_pkg::ACT_NEXT, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || drv_valid) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (LINE_COUNT + 16) @(posedge clk_i);

    if (fail_count == 0)
      $display("memory_lcd_dirty_line_refresh_core test passed");
    else
      $display("memory_lcd_dirty_line_refresh_core test failed");
    $finish;
  end

endmodule
